@@ rtl/core/tbkv_pkg.sv @@
`timescale 1ns / 1ps
package tbkv_pkg;

   localparam int TBKV_BANK_ENTRIES = 256;

   localparam logic [31:0] ERASED_KEY   = 32'hFFFF_FFFF;
   localparam logic [31:0] ERASED_VALUE = 32'hFFFF_FFFF;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [31:0] write_value;
      logic [31:0] miss_value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_value;
      logic        found;
      logic        compacted;
      logic        bank_full;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] key;
      logic [31:0] write_value;
      logic [31:0] miss_value;
   } job_type;

endpackage

@@ rtl/core/tbkv_ram.sv @@
`timescale 1ns / 1ps
module tbkv_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/tbkv_front.sv @@
`timescale 1ns / 1ps
module tbkv_front
   import tbkv_pkg::*;
(
   input  req_type req_data,
   output job_type job
);

   // classify the command
   always_comb begin
      job.key         = req_data.key;
      job.write_value = req_data.write_value;
      job.miss_value  = req_data.miss_value;
      case (req_data.cmd)
         CMD_WRITE: job.op = OP_WRITE;
         CMD_READ:  job.op = OP_READ;
         CMD_CLEAR: job.op = OP_CLEAR;
         default:   job.op = OP_NONE;
      endcase
   end

endmodule

@@ rtl/core/tbkv_queue.sv @@
`timescale 1ns / 1ps
module tbkv_queue
   import tbkv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  job_type req_job,
   output job_type job,
   output logic    job_valid,
   input  logic    job_pop
);

   job_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push;
   logic        pop;

   assign busy      = (cnt_ff == 2'd2);
   assign push      = start && !busy;
   assign job_valid = (cnt_ff != 2'd0);
   assign pop       = job_pop && job_valid;
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ rtl/core/tbkv_back.sv @@
`timescale 1ns / 1ps
module tbkv_back
   import tbkv_pkg::*;
#(
   parameter int BANK_ENTRIES = TBKV_BANK_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  job_type     job,
   input  logic        job_valid,
   output logic        job_pop,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int N     = BANK_ENTRIES;
   localparam int IDX_W = $clog2(N);
   localparam int CNT_W = $clog2(N + 1);
   localparam int DEPTH = 2 * N;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_RD_ISSUE  = 4'd1;
   localparam logic [3:0] ST_RD_CHECK  = 4'd2;
   localparam logic [3:0] ST_CP_ISSUE  = 4'd3;
   localparam logic [3:0] ST_CP_LOAD   = 4'd4;
   localparam logic [3:0] ST_DST_ISSUE = 4'd5;
   localparam logic [3:0] ST_DST_CHECK = 4'd6;
   localparam logic [3:0] ST_CP_WRITE  = 4'd7;
   localparam logic [3:0] ST_CP_NEXT   = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic             active_ff, active_in;
   logic [CNT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      cur_ff, cur_in;
   job_type          job_ff, job_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [63:0]      wr_data;
   logic [AW-1:0]    rd_addr;
   logic [63:0]      rd_data;
   logic [CNT_W-1:0] wr_last;

   function automatic logic [AW-1:0] loc(input logic bank, input logic [IDX_W-1:0] idx);
      loc = AW'(idx) + (bank ? AW'(N) : AW'(0));
   endfunction

   tbkv_ram #(
      .WIDTH (64),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_last = wr_idx_ff - CNT_W'(1);
   assign rd_addr = (state_ff == ST_DST_ISSUE) ? loc(!active_ff, k_ff) : loc(active_ff, ptr_ff);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      wr_idx_in    = wr_idx_ff;
      ptr_in       = ptr_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      job_in       = job_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      job_pop      = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = loc(active_ff, wr_idx_ff[IDX_W-1:0]);
      wr_data      = {job.key, job.write_value};
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               job_in  = job;
               case (job.op)
                  OP_WRITE: begin
                     if (wr_idx_ff == CNT_W'(N)) begin
                        rsp_valid_in     = 1'b1;
                        rsp_in.bank_full = 1'b1;
                     end else begin
                        wr_en     = 1'b1;
                        wr_idx_in = wr_idx_ff + CNT_W'(1);
                        if (wr_idx_ff == CNT_W'(N - 1)) begin
                           ptr_in   = IDX_W'(N - 1);
                           cnt_in   = '0;
                           state_in = ST_CP_ISSUE;
                        end else begin
                           rsp_valid_in = 1'b1;
                        end
                     end
                  end
                  OP_READ: begin
                     if (job.key == ERASED_KEY && wr_idx_ff != CNT_W'(N)) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.read_value = ERASED_VALUE;
                        rsp_in.found      = 1'b1;
                     end else if (wr_idx_ff == '0) begin
                        rsp_valid_in      = 1'b1;
                        rsp_in.read_value = job.miss_value;
                     end else begin
                        ptr_in   = wr_last[IDX_W-1:0];
                        state_in = ST_RD_ISSUE;
                     end
                  end
                  OP_CLEAR: begin
                     active_in    = 1'b0;
                     wr_idx_in    = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_ISSUE: begin
            state_in = ST_RD_CHECK;
         end
         ST_RD_CHECK: begin
            if (rd_data[63:32] == job_ff.key) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_value = rd_data[31:0];
               rsp_in.found      = 1'b1;
               state_in          = ST_IDLE;
            end else if (ptr_ff == '0) begin
               rsp_valid_in      = 1'b1;
               rsp_in.read_value = job_ff.miss_value;
               state_in          = ST_IDLE;
            end else begin
               ptr_in   = ptr_ff - IDX_W'(1);
               state_in = ST_RD_ISSUE;
            end
         end
         ST_CP_ISSUE: begin
            state_in = ST_CP_LOAD;
         end
         ST_CP_LOAD: begin
            cur_in = rd_data;
            if (rd_data[63:32] == ERASED_KEY) begin
               state_in = ST_CP_NEXT;
            end else if (cnt_ff == '0) begin
               state_in = ST_CP_WRITE;
            end else begin
               k_in     = '0;
               state_in = ST_DST_ISSUE;
            end
         end
         ST_DST_ISSUE: begin
            state_in = ST_DST_CHECK;
         end
         ST_DST_CHECK: begin
            if (rd_data[63:32] == cur_ff[63:32]) begin
               state_in = ST_CP_NEXT;
            end else if (CNT_W'(k_ff) + CNT_W'(1) == cnt_ff) begin
               state_in = ST_CP_WRITE;
            end else begin
               k_in     = k_ff + IDX_W'(1);
               state_in = ST_DST_ISSUE;
            end
         end
         ST_CP_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = loc(!active_ff, cnt_ff[IDX_W-1:0]);
            wr_data  = cur_ff;
            cnt_in   = cnt_ff + CNT_W'(1);
            state_in = ST_CP_NEXT;
         end
         ST_CP_NEXT: begin
            if (ptr_ff == '0) begin
               active_in        = !active_ff;
               wr_idx_in        = cnt_ff;
               rsp_valid_in     = 1'b1;
               rsp_in.compacted = 1'b1;
               rsp_in.bank_full = (cnt_ff == CNT_W'(N));
               state_in         = ST_IDLE;
            end else begin
               ptr_in   = ptr_ff - IDX_W'(1);
               state_in = ST_CP_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      cur_ff <= cur_in;
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= 1'b0;
         wr_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         wr_idx_ff    <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_wr_idx_range: assert property (@(posedge clock) disable iff (reset)
      wr_idx_ff <= CNT_W'(N))
      else $error("write cursor past end of bank");

   a_rsp_in_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobed while engine busy");

   a_compact_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.compacted |-> !rsp_ff.found && rsp_ff.read_value == '0)
      else $error("compaction result carries read data");

   a_swap_on_compact: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.compacted |-> active_ff != $past(active_ff))
      else $error("compaction without bank swap");

endmodule

@@ rtl/core/two_bank_log_kv_store.sv @@
`timescale 1ns / 1ps
// Log-structured key/value store over two banks of BANK_ENTRIES 64-bit entries.
// A transaction is taken when start is high and busy is low; two transactions
// can wait in the command queue, and busy is high while both slots are taken.
// Each transaction gives exactly one result, shown for one cycle with
// rsp_valid; the receiver cannot stall it. All time is set by the walk over the
// entry memory, which has one read and one write port: clear, unused commands
// and plain writes finish straight from idle, a read scans entries newest first
// (up to BANK_ENTRIES), each one read and then checked, and a write that fills
// the bank runs compaction: each source entry is read and loaded, compared with
// every kept entry in the other bank, and copied there if its key is new.
// No clearing pass runs after reset: the write cursor marks which entries hold
// data.
module two_bank_log_kv_store
   import tbkv_pkg::*;
#(
   parameter int BANK_ENTRIES = TBKV_BANK_ENTRIES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   job_type req_job;
   job_type job;
   logic    job_valid;
   logic    job_pop;

   tbkv_front u_front (
      .req_data (req_data),
      .job      (req_job)
   );

   tbkv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_job   (req_job),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop)
   );

   tbkv_back #(
      .BANK_ENTRIES (BANK_ENTRIES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_valid (job_valid),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
